// File: sv/orf_codon_scanner_top_assert.svh
// Assertion macros for the checker file of the codon scanner.
`ifndef ORF_CODON_SCANNER_TOP_ASSERT_SVH
`define ORF_CODON_SCANNER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ORF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ORF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/orf_pkg.sv
// Package with the letter codes, register indexes and codon tests of the codon scanner.
`timescale 1ns / 1ps

package orf_pkg;

	localparam int unsigned POS_W = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [7:0] LETTER_A = 8'h41;
	localparam logic [7:0] LETTER_G = 8'h47;
	localparam logic [7:0] LETTER_T = 8'h54;
	localparam logic [7:0] LETTER_U = 8'h55;

	localparam logic [POS_W-1:0] CODON_LETTERS = 16'd3;
	localparam logic [POS_W-1:0] LAST_CODON_OFFSET = 16'd65532;
	localparam logic [POS_W-1:0] MIN_LEN_RESET = 16'd80;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_LEN = 2'd0,
		REG_FRAME_OFFSET = 2'd1,
		REG_REVERSE_STRAND = 2'd2,
		REG_SEQUENCE_LENGTH = 2'd3
	} cfg_reg_t;

	function automatic logic is_t_or_u(input logic [7:0] c);
		return c inside {LETTER_T, LETTER_U};
	endfunction

	function automatic logic is_a_or_g(input logic [7:0] c);
		return c inside {LETTER_A, LETTER_G};
	endfunction

	function automatic logic codon_starts(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		return (a == LETTER_A) && is_t_or_u(b) && (c == LETTER_G);
	endfunction

	function automatic logic codon_stops(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		return is_t_or_u(a) && is_a_or_g(b) && is_a_or_g(c)
			&& !((b == LETTER_G) && (c == LETTER_G));
	endfunction

endpackage

// File: sv/orf_codon_scanner_top.sv
// Top level of the codon scanner: input register, codon logic and result register.
// A fragment's result is written into the result register as its closing codon leaves the input register.
// One codon is taken in every cycle; a codon stalls only when it brings a result
// while the result register is still held by the output side.
// Reset clears the letter position, the open fragment, both valid flags and
// returns the registers to min_len 80, frame 0, forward strand, length 0.
`timescale 1ns / 1ps

module orf_codon_scanner_top (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_write,
	input  logic [orf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [orf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [7:0] base_first,
	input  logic [7:0] base_second,
	input  logic [7:0] base_third,
	input  logic last_codon,
	output logic out_valid,
	input  logic out_stall,
	output logic [15:0] orf_begin,
	output logic [15:0] orf_end,
	output logic [15:0] orf_letters
);

	import orf_pkg::*;

	logic [POS_W-1:0] min_len_q;
	logic [1:0] frame_offset_q;
	logic reverse_strand_q;
	logic [POS_W-1:0] sequence_length_q;

	logic [POS_W-1:0] pos_q;
	logic rec_q;
	logic [POS_W-1:0] beg_q;

	logic valid_s1;
	logic [7:0] first_s1;
	logic [7:0] second_s1;
	logic [7:0] third_s1;
	logic last_s1;

	logic out_valid_q;
	logic [POS_W-1:0] begin_q;
	logic [POS_W-1:0] end_q;
	logic [POS_W-1:0] letters_q;

	logic start_hit;
	logic rec_eff;
	logic [POS_W-1:0] beg_eff;
	logic close_hit;
	logic keep;
	logic [POS_W-1:0] stop_pos;
	logic [POS_W-1:0] letters;
	logic [POS_W-1:0] lo_place;
	logic [POS_W-1:0] hi_place;
	logic out_free;
	logic advance;
	logic in_take;

	function automatic logic [POS_W-1:0] place(input logic [POS_W-1:0] x,
			input logic [1:0] fo, input logic rev, input logic [POS_W-1:0] len);
		logic [POS_W:0] v;
		logic [POS_W:0] len_ext;
		v = {1'b0, x} + {{(POS_W-1){1'b0}}, fo};
		len_ext = {1'b0, len};
		if (rev) begin
			v = (len_ext >= v) ? (len_ext - v) : '0;
		end
		return v[POS_W] ? {POS_W{1'b1}} : v[POS_W-1:0];
	endfunction

	always_comb begin
		start_hit = !rec_q && codon_starts(first_s1, second_s1, third_s1);
		rec_eff = rec_q || start_hit;
		beg_eff = start_hit ? pos_q : beg_q;
		close_hit = rec_eff && (codon_stops(first_s1, second_s1, third_s1) || last_s1);
		stop_pos = pos_q + CODON_LETTERS;
		letters = stop_pos - beg_eff;
		keep = close_hit && (letters >= min_len_q);
		lo_place = place(beg_eff, frame_offset_q, reverse_strand_q, sequence_length_q);
		hi_place = place(stop_pos, frame_offset_q, reverse_strand_q, sequence_length_q);
	end

	assign out_free = !out_valid_q || !out_stall;
	assign advance = valid_s1 && (!keep || out_free);
	assign in_stall = valid_s1 && !advance;
	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= MIN_LEN_RESET;
			frame_offset_q <= '0;
			reverse_strand_q <= 1'b0;
			sequence_length_q <= '0;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_MIN_LEN: min_len_q <= cfg_data;
				REG_FRAME_OFFSET: frame_offset_q <= cfg_data[1:0];
				REG_REVERSE_STRAND: reverse_strand_q <= cfg_data[0];
				REG_SEQUENCE_LENGTH: sequence_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			first_s1 <= base_first;
			second_s1 <= base_second;
			third_s1 <= base_third;
			last_s1 <= last_codon;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			rec_q <= 1'b0;
			beg_q <= '0;
		end else if (advance) begin
			beg_q <= beg_eff;
			if (last_s1) begin
				pos_q <= '0;
				rec_q <= 1'b0;
			end else begin
				rec_q <= rec_eff && !close_hit;
				if (pos_q <= (LAST_CODON_OFFSET - CODON_LETTERS)) begin
					pos_q <= stop_pos;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && keep) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && keep) begin
			begin_q <= (lo_place > hi_place) ? hi_place : lo_place;
			end_q <= (lo_place > hi_place) ? lo_place : hi_place;
			letters_q <= letters;
		end
	end

	assign out_valid = out_valid_q;
	assign orf_begin = begin_q;
	assign orf_end = end_q;
	assign orf_letters = letters_q;

endmodule

// File: sv/orf_checker.sv
// Port-level checker for the codon scanner and its bind to the top level.
`timescale 1ns / 1ps

`include "orf_codon_scanner_top_assert.svh"

module orf_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [15:0] orf_begin,
	input logic [15:0] orf_end,
	input logic [15:0] orf_letters
);

	import orf_pkg::*;

	logic [47:0] result_bits;

	assign result_bits = {orf_begin, orf_end, orf_letters};

	`ORF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result_bits), "result changed")
	`ORF_ASSERT_NOW(a_order, out_valid, orf_begin <= orf_end, "result offsets out of order")
	`ORF_ASSERT_NOW(a_min_letters, out_valid, orf_letters >= CODON_LETTERS, "fragment below one codon")
	`ORF_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled, no held result")

endmodule

bind orf_codon_scanner_top orf_checker u_orf_checker (.*);
